FILE: design/hdep_pkg.sv
// Types and constants shared by the HTTP date expiry parser modules.
// No dependencies.
`default_nettype none

package hdep_pkg;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_FORMAT  = 3'd2,
    ST_ZONE    = 3'd3,
    ST_RANGE   = 3'd4,
    ST_EXPIRED = 3'd5
  } status_t;

  localparam logic [4:0]  DATE_LEN      = 5'd29;
  localparam logic [13:0] EPOCH_YEAR    = 14'd1970;
  localparam logic [3:0]  MONTH_INVALID = 4'd15;
  localparam logic [3:0]  MONTH_LAST    = 4'd11;
  localparam logic [6:0]  DAY_MAX       = 7'd31;
  localparam logic [6:0]  HOURS_PER_DAY = 7'd24;
  localparam logic [6:0]  MIN_PER_HOUR  = 7'd60;
  localparam logic [23:0] ZONE_GMT      = 24'h474D54;
  localparam logic [23:0] ZONE_UTC      = 24'h555443;

  // Record handed from the parser front to the time computation back end.
  typedef struct packed {
    status_t      pre;
    logic [13:0]  year;
    logic [3:0]   month;
    logic [4:0]   day;
    logic [4:0]   hour;
    logic [5:0]   minute;
    logic [5:0]   second;
    logic [62:0]  now;
  } date_rec_t;

  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] d;
    unique case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: design/hdep_front.sv
// Byte-wise parser front: tracks position, accumulates fields, classifies on last.
// Depends on hdep_pkg.
`default_nettype none

module hdep_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_last,
  input  wire logic [62:0]       in_now_seconds,
  input  wire logic              q_full,
  output logic                   q_wr,
  output hdep_pkg::date_rec_t    q_rec
);

  localparam logic [4:0] POS_COMMA = 5'd3;
  localparam logic [4:0] POS_SPACE = 5'd4;
  localparam logic [4:0] POS_DAY   = 5'd5;
  localparam logic [4:0] POS_MON   = 5'd8;
  localparam logic [4:0] POS_YEAR  = 5'd12;
  localparam logic [4:0] POS_HOUR  = 5'd17;
  localparam logic [4:0] POS_MIN   = 5'd20;
  localparam logic [4:0] POS_SEC   = 5'd23;
  localparam logic [4:0] POS_ZONE  = 5'd26;

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic [6:0] acc7(input logic [6:0] acc, input logic first,
                                      input logic take, input logic [3:0] d);
    logic [6:0] base;
    base = first ? 7'd0 : acc;
    return take ? 7'(10'(base) * 10'd10 + 10'(d)) : base;
  endfunction

  function automatic logic [13:0] acc14(input logic [13:0] acc, input logic first,
                                        input logic take, input logic [3:0] d);
    logic [13:0] base;
    base = first ? 14'd0 : acc;
    return take ? 14'(18'(base) * 18'd10 + 18'(d)) : base;
  endfunction

  function automatic logic [3:0] decode_month(input logic [23:0] s);
    logic [3:0] m;
    unique case (s)
      "jan":   m = 4'd0;
      "feb":   m = 4'd1;
      "mar":   m = 4'd2;
      "apr":   m = 4'd3;
      "may":   m = 4'd4;
      "jun":   m = 4'd5;
      "jul":   m = 4'd6;
      "aug":   m = 4'd7;
      "sep":   m = 4'd8;
      "oct":   m = 4'd9;
      "nov":   m = 4'd10;
      "dec":   m = 4'd11;
      default: m = hdep_pkg::MONTH_INVALID;
    endcase
    return m;
  endfunction

  logic [4:0]  position_r, position_nxt, pos_upd;
  logic [6:0]  day_acc_r, day_acc_nxt, day_upd;
  logic [15:0] month_letters_r, month_letters_nxt, mlet_upd;
  logic [3:0]  month_code_r, month_code_nxt, mcode_upd;
  logic [13:0] year_acc_r, year_acc_nxt, year_upd;
  logic [6:0]  hour_acc_r, hour_acc_nxt, hour_upd;
  logic [6:0]  minute_acc_r, minute_acc_nxt, min_upd;
  logic [6:0]  second_acc_r, second_acc_nxt, sec_upd;
  logic        field_stopped_r, field_stopped_nxt, stop_upd;
  logic        format_ok_r, format_ok_nxt, fmt_upd;
  logic [23:0] zone_letters_r, zone_letters_nxt, zone_upd;

  logic        accept;
  logic        is_digit;
  logic [3:0]  digit;
  logic        first, in_field, take;
  logic        f_day, f_year, f_hour, f_min, f_sec;
  logic        range_bad;
  hdep_pkg::status_t pre;

  assign accept   = in_push && !q_full;
  assign is_digit = (in_byte >= "0") && (in_byte <= "9");
  assign digit    = in_byte[3:0];

  assign f_day  = (position_r == POS_DAY)  || (position_r == POS_DAY + 5'd1);
  assign f_year = (position_r >= POS_YEAR) && (position_r <= POS_YEAR + 5'd3);
  assign f_hour = (position_r == POS_HOUR) || (position_r == POS_HOUR + 5'd1);
  assign f_min  = (position_r == POS_MIN)  || (position_r == POS_MIN + 5'd1);
  assign f_sec  = (position_r == POS_SEC)  || (position_r == POS_SEC + 5'd1);
  assign first  = (position_r == POS_DAY) || (position_r == POS_YEAR) ||
                  (position_r == POS_HOUR) || (position_r == POS_MIN) ||
                  (position_r == POS_SEC);
  assign in_field = f_day || f_year || f_hour || f_min || f_sec;
  assign take     = is_digit && (first || !field_stopped_r);

  always_comb begin
    pos_upd   = position_r;
    day_upd   = day_acc_r;
    mlet_upd  = month_letters_r;
    mcode_upd = month_code_r;
    year_upd  = year_acc_r;
    hour_upd  = hour_acc_r;
    min_upd   = minute_acc_r;
    sec_upd   = second_acc_r;
    stop_upd  = field_stopped_r;
    fmt_upd   = format_ok_r;
    zone_upd  = zone_letters_r;
    if (position_r < hdep_pkg::DATE_LEN) begin
      pos_upd = position_r + 5'd1;
      if (position_r == POS_COMMA && in_byte != ",") fmt_upd = 1'b0;
      if (position_r == POS_SPACE && in_byte != " ") fmt_upd = 1'b0;
      if (in_field) stop_upd = !take;
      if (f_day)  day_upd  = acc7(day_acc_r, first, take, digit);
      if (f_year) year_upd = acc14(year_acc_r, first, take, digit);
      if (f_hour) hour_upd = acc7(hour_acc_r, first, take, digit);
      if (f_min)  min_upd  = acc7(minute_acc_r, first, take, digit);
      if (f_sec)  sec_upd  = acc7(second_acc_r, first, take, digit);
      if (position_r == POS_MON) mlet_upd = {lower_ascii(in_byte), 8'd0};
      if (position_r == POS_MON + 5'd1) mlet_upd = {month_letters_r[15:8], lower_ascii(in_byte)};
      if (position_r == POS_MON + 5'd2)
        mcode_upd = decode_month({month_letters_r, lower_ascii(in_byte)});
      if (position_r >= POS_ZONE) zone_upd = {zone_letters_r[15:0], in_byte};
    end
  end

  assign range_bad = (mcode_upd > hdep_pkg::MONTH_LAST) || (day_upd == 7'd0) ||
                     (day_upd > hdep_pkg::DAY_MAX) || (year_upd < hdep_pkg::EPOCH_YEAR) ||
                     (hour_upd >= hdep_pkg::HOURS_PER_DAY) ||
                     (min_upd >= hdep_pkg::MIN_PER_HOUR) ||
                     (sec_upd >= hdep_pkg::MIN_PER_HOUR);

  always_comb begin
    if (pos_upd < hdep_pkg::DATE_LEN) begin
      pre = hdep_pkg::ST_SHORT;
    end else if (!fmt_upd) begin
      pre = hdep_pkg::ST_FORMAT;
    end else if (zone_upd != hdep_pkg::ZONE_GMT && zone_upd != hdep_pkg::ZONE_UTC) begin
      pre = hdep_pkg::ST_ZONE;
    end else if (range_bad) begin
      pre = hdep_pkg::ST_RANGE;
    end else begin
      pre = hdep_pkg::ST_OK;
    end
  end

  assign q_wr         = accept && in_last;
  assign q_rec.pre    = pre;
  assign q_rec.year   = year_upd;
  assign q_rec.month  = mcode_upd;
  assign q_rec.day    = day_upd[4:0];
  assign q_rec.hour   = hour_upd[4:0];
  assign q_rec.minute = min_upd[5:0];
  assign q_rec.second = sec_upd[5:0];
  assign q_rec.now    = in_now_seconds;

  always_comb begin
    position_nxt      = position_r;
    day_acc_nxt       = day_acc_r;
    month_letters_nxt = month_letters_r;
    month_code_nxt    = month_code_r;
    year_acc_nxt      = year_acc_r;
    hour_acc_nxt      = hour_acc_r;
    minute_acc_nxt    = minute_acc_r;
    second_acc_nxt    = second_acc_r;
    field_stopped_nxt = field_stopped_r;
    format_ok_nxt     = format_ok_r;
    zone_letters_nxt  = zone_letters_r;
    if (accept && in_last) begin
      position_nxt      = '0;
      day_acc_nxt       = '0;
      month_letters_nxt = '0;
      month_code_nxt    = hdep_pkg::MONTH_INVALID;
      year_acc_nxt      = '0;
      hour_acc_nxt      = '0;
      minute_acc_nxt    = '0;
      second_acc_nxt    = '0;
      field_stopped_nxt = 1'b0;
      format_ok_nxt     = 1'b1;
      zone_letters_nxt  = '0;
    end else if (accept) begin
      position_nxt      = pos_upd;
      day_acc_nxt       = day_upd;
      month_letters_nxt = mlet_upd;
      month_code_nxt    = mcode_upd;
      year_acc_nxt      = year_upd;
      hour_acc_nxt      = hour_upd;
      minute_acc_nxt    = min_upd;
      second_acc_nxt    = sec_upd;
      field_stopped_nxt = stop_upd;
      format_ok_nxt     = fmt_upd;
      zone_letters_nxt  = zone_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r      <= '0;
      day_acc_r       <= '0;
      month_letters_r <= '0;
      month_code_r    <= hdep_pkg::MONTH_INVALID;
      year_acc_r      <= '0;
      hour_acc_r      <= '0;
      minute_acc_r    <= '0;
      second_acc_r    <= '0;
      field_stopped_r <= 1'b0;
      format_ok_r     <= 1'b1;
      zone_letters_r  <= '0;
    end else begin
      position_r      <= position_nxt;
      day_acc_r       <= day_acc_nxt;
      month_letters_r <= month_letters_nxt;
      month_code_r    <= month_code_nxt;
      year_acc_r      <= year_acc_nxt;
      hour_acc_r      <= hour_acc_nxt;
      minute_acc_r    <= minute_acc_nxt;
      second_acc_r    <= second_acc_nxt;
      field_stopped_r <= field_stopped_nxt;
      format_ok_r     <= format_ok_nxt;
      zone_letters_r  <= zone_letters_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last) |=> (position_r == 5'd0 && format_ok_r &&
                             month_code_r == hdep_pkg::MONTH_INVALID))
    else $error("parser state not cleared after last item");
  a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (position_r == hdep_pkg::DATE_LEN && !(accept && in_last)) |=>
      (position_r == hdep_pkg::DATE_LEN))
    else $error("position left saturation");
`endif

endmodule

`default_nettype wire

FILE: design/hdep_fifo.sv
// Short record queue between the parser front and the time computation back end.
// Depends on hdep_pkg.
`default_nettype none

module hdep_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire hdep_pkg::date_rec_t  wr_data,
  output logic                      full,
  input  wire logic                 rd_en,
  output hdep_pkg::date_rec_t       rd_data,
  output logic                      empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  hdep_pkg::date_rec_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_wr && !do_rd) count_r <= count_r + 1'b1;
      else if (do_rd && !do_wr) count_r <= count_r - 1'b1;
    end
  end

`ifndef ASSERT_OFF
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("record queue overflow");
`endif

endmodule

`default_nettype wire

FILE: design/hdep_back.sv
// Back end: five-stage pipeline turning a parsed date into epoch seconds,
// expiry compare, and a two-entry result buffer. Depends on hdep_pkg.
`default_nettype none

module hdep_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_empty,
  output logic                      q_rd,
  input  wire hdep_pkg::date_rec_t  q_rec,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output logic [2:0]                out_status,
  output logic [37:0]               out_expires_seconds
);

  logic adv;

  // stage 1
  logic                s1_v_r;
  hdep_pkg::status_t   s1_pre_r;
  logic [13:0]         s1_year_r;
  logic [3:0]          s1_month_r;
  logic [4:0]          s1_day_r;
  logic [7:0]          s1_q100y_r, s1_q100m_r;
  logic [16:0]         s1_tod_r;
  logic [62:0]         s1_now_r;
  logic [26:0]         prod_y, prod_m;
  logic [13:0]         q_ym1;

  // stage 2
  logic                s2_v_r;
  hdep_pkg::status_t   s2_pre_r;
  logic [3:0]          s2_month_r;
  logic [4:0]          s2_day_r;
  logic [22:0]         s2_base_r;
  logic [12:0]         s2_leaps_r;
  logic                s2_leap_r;
  logic [16:0]         s2_tod_r;
  logic [62:0]         s2_now_r;
  logic [13:0]         s1_ym1, s1_hundred;
  logic                s1_rzero;

  // stage 3 .. 5
  logic                s3_v_r, s4_v_r, s5_v_r;
  hdep_pkg::status_t   s3_pre_r, s4_pre_r, s5_pre_r;
  logic [22:0]         s3_days_r;
  logic [16:0]         s3_tod_r, s4_tod_r;
  logic [62:0]         s3_now_r, s4_now_r, s5_now_r;
  logic [38:0]         s4_prod_r, s5_secs_r;
  logic                leap_add;

  // result buffer
  hdep_pkg::status_t   ob_status [2];
  logic [37:0]         ob_secs [2];
  logic                ob_wr_ptr_r, ob_rd_ptr_r;
  logic [1:0]          ob_cnt_r;
  logic                ob_full, ob_wr, ob_rd;
  logic                expired;
  hdep_pkg::status_t   fin_status;
  logic [37:0]         fin_secs;

  assign ob_full = (ob_cnt_r == 2'd2);
  assign adv     = !s5_v_r || !ob_full;
  assign q_rd    = adv && !q_empty;

  // y/100 by reciprocal, exact for 14-bit y
  assign q_ym1  = q_rec.year - 14'd1;
  assign prod_y = 27'(q_rec.year) * 27'd5243;
  assign prod_m = 27'(q_ym1) * 27'd5243;

  assign s1_ym1     = s1_year_r - 14'd1;
  assign s1_hundred = 14'(s1_q100y_r) * 14'd100;
  assign s1_rzero   = (s1_year_r == s1_hundred);

  assign leap_add = s2_leap_r && (s2_month_r > 4'd1);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pre_r   <= q_rec.pre;
      s1_year_r  <= q_rec.year;
      s1_month_r <= q_rec.month;
      s1_day_r   <= q_rec.day;
      s1_q100y_r <= prod_y[26:19];
      s1_q100m_r <= prod_m[26:19];
      s1_tod_r   <= 17'(q_rec.hour) * 17'd3600 + 17'(q_rec.minute) * 17'd60
                    + 17'(q_rec.second);
      s1_now_r   <= q_rec.now;

      s2_pre_r   <= s1_pre_r;
      s2_month_r <= s1_month_r;
      s2_day_r   <= s1_day_r;
      s2_base_r  <= 23'(s1_year_r - hdep_pkg::EPOCH_YEAR) * 23'd365;
      s2_leaps_r <= 13'(s1_ym1[13:2]) + 13'(s1_q100m_r[7:2]) - 13'(s1_q100m_r);
      s2_leap_r  <= (s1_year_r[1:0] == 2'd0 && !s1_rzero) ||
                    (s1_rzero && s1_q100y_r[1:0] == 2'd0);
      s2_tod_r   <= s1_tod_r;
      s2_now_r   <= s1_now_r;

      s3_pre_r   <= s2_pre_r;
      s3_days_r  <= s2_base_r + 23'(s2_leaps_r) - 23'd477
                    + 23'(hdep_pkg::days_before(s2_month_r)) + 23'(leap_add)
                    + 23'(s2_day_r) - 23'd1;
      s3_tod_r   <= s2_tod_r;
      s3_now_r   <= s2_now_r;

      s4_pre_r   <= s3_pre_r;
      s4_prod_r  <= 39'(s3_days_r) * 39'd86400;
      s4_tod_r   <= s3_tod_r;
      s4_now_r   <= s3_now_r;

      s5_pre_r   <= s4_pre_r;
      s5_secs_r  <= s4_prod_r + 39'(s4_tod_r);
      s5_now_r   <= s4_now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= !q_empty;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  assign expired = (63'(s5_secs_r) < s5_now_r);

  always_comb begin
    fin_status = s5_pre_r;
    fin_secs   = '0;
    if (s5_pre_r == hdep_pkg::ST_OK) begin
      if (expired) begin
        fin_status = hdep_pkg::ST_EXPIRED;
      end else begin
        fin_secs = s5_secs_r[37:0];
      end
    end
  end

  assign ob_wr = s5_v_r && adv;
  assign ob_rd = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (ob_wr) begin
      ob_status[ob_wr_ptr_r] <= fin_status;
      ob_secs[ob_wr_ptr_r]   <= fin_secs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wr_ptr_r <= 1'b0;
      ob_rd_ptr_r <= 1'b0;
      ob_cnt_r    <= 2'd0;
    end else begin
      if (ob_wr) ob_wr_ptr_r <= !ob_wr_ptr_r;
      if (ob_rd) ob_rd_ptr_r <= !ob_rd_ptr_r;
      if (ob_wr && !ob_rd) ob_cnt_r <= ob_cnt_r + 2'd1;
      else if (ob_rd && !ob_wr) ob_cnt_r <= ob_cnt_r - 2'd1;
    end
  end

  assign out_empty           = (ob_cnt_r == 2'd0);
  assign out_status          = ob_status[ob_rd_ptr_r];
  assign out_expires_seconds = ob_secs[ob_rd_ptr_r];

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s5_v_r && !adv) |=> (s5_v_r && $stable(s5_secs_r)))
    else $error("stalled result dropped");
  a_ob_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    ob_cnt_r <= 2'd2)
    else $error("result buffer overflow");
`endif

endmodule

`default_nettype wire

FILE: design/http_date_expiry_parser_core.sv
// HTTP date expiry parser: top level joining parser front, record queue and back end.
// Depends on hdep_pkg, hdep_front, hdep_fifo, hdep_back.
//
// Usage: the date string enters one byte per item on the in_ queue port
// (in_push / in_full); in_last marks the final byte and in_now_seconds is
// sampled with it. Each string gives one result on the out_ queue port
// (out_empty / out_pop): out_status and out_expires_seconds.
// Throughput: one byte per cycle, including a string's last byte, as long as
// results are popped; strings of one byte each can also run at one per cycle.
// The last byte's record is written into the record queue; five pipeline stages
// then compute the day count, the 23x17 bit seconds multiply and the
// time-of-day add, and the expiry compare on the stage 5 result is registered
// into the result buffer, from which the result is visible.
// Reset clears the parser to position 0 and empties all queues.
// When the receiver stalls, the two-entry result buffer fills, the pipeline
// holds, then the QUEUE_DEPTH record queue fills and in_full rises.
`default_nettype none

module http_date_expiry_parser_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_push,
  output logic              in_full,
  input  wire logic [7:0]   in_byte,
  input  wire logic         in_last,
  input  wire logic [62:0]  in_now_seconds,
  output logic              out_empty,
  input  wire logic         out_pop,
  output logic [2:0]        out_status,
  output logic [37:0]       out_expires_seconds
);

  hdep_pkg::date_rec_t wr_rec, rd_rec;
  logic q_wr, q_full, q_rd, q_empty;

  assign in_full = q_full;

  hdep_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .in_now_seconds (in_now_seconds),
    .q_full         (q_full),
    .q_wr           (q_wr),
    .q_rec          (wr_rec)
  );

  hdep_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (wr_rec),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (rd_rec),
    .empty   (q_empty)
  );

  hdep_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_rd                (q_rd),
    .q_rec               (rd_rec),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_status          (out_status),
    .out_expires_seconds (out_expires_seconds)
  );

endmodule

`default_nettype wire

FILE: tb/sv/hdep_expiry_check.sv
// Scoreboard for http_date_expiry_parser_core: predicts status and expiry seconds per date string
// and compares them with popped results. Depends on hdep_pkg; also holds hdep_tb_pkg (date math).
`timescale 1ns / 1ps

package hdep_tb_pkg;

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint unsigned leaps_upto(input longint unsigned y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  // mon is 0-based; a day past the month's end rolls into the next month
  function automatic longint unsigned civil_seconds(input int unsigned y, input int unsigned mon,
      input int unsigned d, input int unsigned hh, input int unsigned mm, input int unsigned ss);
    longint unsigned days;
    int unsigned n;
    days = 365 * longint'(y - 1970) + leaps_upto(y - 1) - leaps_upto(1969);
    for (int unsigned i = 0; i < mon; i++) begin
      n = i + 1;
      days += (n == 2) ? 28 : 30 + ((n + n / 8) & 1);
    end
    if (leap_year(y) && mon > 1) days += 1;
    days += d - 1;
    return days * 86400 + hh * 3600 + mm * 60 + ss;
  endfunction

endpackage

module hdep_expiry_check (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  input  wire logic        in_full,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  input  wire logic [62:0] in_now_seconds,
  input  wire logic        out_empty,
  input  wire logic        out_pop,
  input  wire logic [2:0]  out_status,
  input  wire logic [37:0] out_expires_seconds,
  output int               fail_count,
  output int               backlog,
  output int               results_all,
  output int               results_ok,
  output int               results_expired
);

  typedef struct {
    hdep_pkg::status_t status;
    logic [37:0]       secs;
  } expiry_t;

  expiry_t     expiry_q[$];
  int          errs, n_all, n_ok, n_exp;
  logic [4:0]  pos;
  logic [6:0]  day_v, hour_v, min_v, sec_v;
  logic [7:0]  mon_a, mon_b;
  logic [3:0]  mon_idx;
  logic [13:0] year_v;
  logic [23:0] zone_v;
  bit          stopped, layout_ok;

  function automatic void clear_parser();
    pos = '0;
    day_v = '0;
    hour_v = '0;
    min_v = '0;
    sec_v = '0;
    mon_a = '0;
    mon_b = '0;
    mon_idx = hdep_pkg::MONTH_INVALID;
    year_v = '0;
    zone_v = '0;
    stopped = 1'b0;
    layout_ok = 1'b1;
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? 8'(c + 8'd32) : c;
  endfunction

  function automatic int digit_step(input int acc, input logic [7:0] c, input bit first);
    if (first) begin
      stopped = 1'b0;
      acc = 0;
    end
    if (!stopped && c >= "0" && c <= "9") return acc * 10 + int'(c - "0");
    stopped = 1'b1;
    return acc;
  endfunction

  function automatic logic [3:0] month_index(input logic [23:0] abc);
    case (abc)
      "jan": return 4'd0;
      "feb": return 4'd1;
      "mar": return 4'd2;
      "apr": return 4'd3;
      "may": return 4'd4;
      "jun": return 4'd5;
      "jul": return 4'd6;
      "aug": return 4'd7;
      "sep": return 4'd8;
      "oct": return 4'd9;
      "nov": return 4'd10;
      "dec": return 4'd11;
      default: return hdep_pkg::MONTH_INVALID;
    endcase
  endfunction

  task automatic parse_date_byte(input logic [7:0] c, input bit is_last, input logic [62:0] now);
    hdep_pkg::status_t st;
    longint unsigned   secs;
    secs = 0;
    if (pos < hdep_pkg::DATE_LEN) begin
      if (pos == 5'd3 && c != ",") layout_ok = 1'b0;
      if (pos == 5'd4 && c != " ") layout_ok = 1'b0;
      if (pos == 5'd5 || pos == 5'd6) day_v = 7'(digit_step(day_v, c, pos == 5'd5));
      if (pos == 5'd8) mon_a = fold_case(c);
      if (pos == 5'd9) mon_b = fold_case(c);
      if (pos == 5'd10) mon_idx = month_index({mon_a, mon_b, fold_case(c)});
      if (pos >= 5'd12 && pos <= 5'd15) year_v = 14'(digit_step(year_v, c, pos == 5'd12));
      if (pos == 5'd17 || pos == 5'd18) hour_v = 7'(digit_step(hour_v, c, pos == 5'd17));
      if (pos == 5'd20 || pos == 5'd21) min_v = 7'(digit_step(min_v, c, pos == 5'd20));
      if (pos == 5'd23 || pos == 5'd24) sec_v = 7'(digit_step(sec_v, c, pos == 5'd23));
      if (pos >= 5'd26) zone_v = {zone_v[15:0], c};
      pos = pos + 5'd1;
    end
    if (!is_last) return;
    if (pos < hdep_pkg::DATE_LEN) st = hdep_pkg::ST_SHORT;
    else if (!layout_ok) st = hdep_pkg::ST_FORMAT;
    else if (zone_v != hdep_pkg::ZONE_GMT && zone_v != hdep_pkg::ZONE_UTC)
      st = hdep_pkg::ST_ZONE;
    else if (mon_idx > hdep_pkg::MONTH_LAST || day_v == 7'd0 || day_v > hdep_pkg::DAY_MAX ||
             year_v < hdep_pkg::EPOCH_YEAR || hour_v >= hdep_pkg::HOURS_PER_DAY ||
             min_v >= hdep_pkg::MIN_PER_HOUR || sec_v >= hdep_pkg::MIN_PER_HOUR)
      st = hdep_pkg::ST_RANGE;
    else begin
      secs = hdep_tb_pkg::civil_seconds(year_v, mon_idx, day_v, hour_v, min_v, sec_v);
      if (secs < now) begin
        st = hdep_pkg::ST_EXPIRED;
        secs = 0;
      end else begin
        st = hdep_pkg::ST_OK;
      end
    end
    expiry_q.push_back('{st, secs[37:0]});
    clear_parser();
  endtask

  always @(posedge clk) begin
    expiry_t want;
    if (!rst_n) begin
      clear_parser();
      expiry_q.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (expiry_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected result: status %0d seconds %0d", $time, out_status,
                   out_expires_seconds);
        end else begin
          want = expiry_q.pop_front();
          n_all++;
          if (want.status == hdep_pkg::ST_OK) n_ok++;
          if (want.status == hdep_pkg::ST_EXPIRED) n_exp++;
          if (out_status !== want.status) begin
            errs++;
            $display("%0t: status mismatch: expected %0d (%s) got %0d", $time, want.status,
                     want.status.name(), out_status);
          end
          if (out_expires_seconds !== want.secs) begin
            errs++;
            $display("%0t: expires_seconds mismatch: expected %0d got %0d", $time, want.secs,
                     out_expires_seconds);
          end
        end
      end
      if (in_push && !in_full) parse_date_byte(in_byte, in_last, in_now_seconds);
    end
    fail_count <= errs;
    backlog <= expiry_q.size();
    results_all <= n_all;
    results_ok <= n_ok;
    results_expired <= n_exp;
  end

endmodule

FILE: tb/sv/tb.sv
// Top-level testbench for http_date_expiry_parser_core: drives date strings byte by byte with
// random gaps and result stalls. Depends on hdep_pkg, hdep_expiry_check, hdep_tb_pkg.
`timescale 1ns / 1ps

module tb;

  localparam int BYTE_TARGET  = 2000;
  localparam int CALM_FROM    = 1700;
  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 12;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [7:0]  in_byte;
  logic        in_last;
  logic [62:0] in_now_seconds;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [2:0]  out_status;
  logic [37:0] out_expires_seconds;

  int fail_count, backlog, results_all, results_ok, results_expired;
  int n_bytes, n_strings, quiet, pop_stall;
  bit calm;
  logic [7:0] date_buf[$];
  string month_names[12] = '{"Jan", "Feb", "Mar", "Apr", "May", "Jun",
                             "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"};

  http_date_expiry_parser_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_byte             (in_byte),
    .in_last             (in_last),
    .in_now_seconds      (in_now_seconds),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_status          (out_status),
    .out_expires_seconds (out_expires_seconds)
  );

  hdep_expiry_check chk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_byte             (in_byte),
    .in_last             (in_last),
    .in_now_seconds      (in_now_seconds),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_status          (out_status),
    .out_expires_seconds (out_expires_seconds),
    .fail_count          (fail_count),
    .backlog             (backlog),
    .results_all         (results_all),
    .results_ok          (results_ok),
    .results_expired     (results_expired)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_stall <= 0;
    end else if (pop_stall > 0) begin
      out_pop <= 1'b0;
      pop_stall <= pop_stall - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_pop <= 1'b0;
      pop_stall <= $urandom_range(0, 14);
    end else begin
      out_pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
      $display("** http_date_expiry_parser_core: FAILED **");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [62:0] rand63();
    return 63'({$urandom, $urandom});
  endfunction

  function automatic logic [7:0] rand_letter();
    return 8'(($urandom_range(0, 1) != 0 ? 8'h61 : 8'h41) + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] scramble_case(input logic [7:0] c);
    if (((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) && $urandom_range(0, 1) != 0)
      return c ^ 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] odd_byte();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'h80 | 8'($urandom);
      2: return 8'(8'h30 + $urandom_range(0, 9));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [62:0] pick_now(input longint unsigned secs);
    case ($urandom_range(0, 6))
      0: return '0;
      1: return 63'(secs);
      2: return 63'(secs + 1);
      3: return (secs > 0) ? 63'(secs - 1) : '0;
      4: return 63'(secs + $urandom_range(0, 100000));
      5: return (secs > 100000) ? 63'(secs - $urandom_range(0, 100000)) : '0;
      default: return rand63();
    endcase
  endfunction

  task automatic load_text(input string s);
    date_buf.delete();
    for (int i = 0; i < s.len(); i++) date_buf.push_back(s[i]);
  endtask

  // m < 0 gives three random letters in the month field
  task automatic load_date(input int d, input int m, input int y, input int h, input int mi,
                           input int s, input string zone);
    string mon;
    mon = (m >= 0) ? month_names[m]
                   : $sformatf("%c%c%c", rand_letter(), rand_letter(), rand_letter());
    load_text($sformatf("%c%c%c, %02d %s %04d %02d:%02d:%02d %s", rand_letter(), rand_letter(),
                        rand_letter(), d, mon, y, h, mi, s, zone));
    for (int i = 8; i <= 10; i++) date_buf[i] = scramble_case(date_buf[i]);
  endtask

  task automatic send_buf(input logic [62:0] now);
    for (int i = 0; i < date_buf.size(); i++) begin
      in_push <= 1'b1;
      in_byte <= date_buf[i];
      in_last <= (i == date_buf.size() - 1);
      in_now_seconds <= (i == date_buf.size() - 1) ? now : rand63();
      @(posedge clk);
      while (in_full) @(posedge clk);
      n_bytes++;
      calm = (n_bytes >= CALM_FROM);
      if (!calm && $urandom_range(0, 11) == 0) begin
        in_push <= 1'b0;
        in_byte <= 8'($urandom);
        in_last <= 1'($urandom);
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
    n_strings++;
  endtask

  task automatic directed_dates();
    load_text("Sun, 06 Nov 1994 08:49:37 GMT");
    send_buf('0);
    load_text("Thu, 01 Jan 1970 00:00:00 UTC");
    send_buf('0);
    load_text("Thu, 01 jAN 1970 00:00:00 GMT");
    send_buf(63'd1);
    load_text("Fri, 31 Dec 9999 23:59:59 GMT");
    send_buf(63'(hdep_tb_pkg::civil_seconds(9999, 11, 31, 23, 59, 59)));
    load_text("Fri, 31 DEC 9999 23:59:59 UTC");
    send_buf('1);
    load_text("Tue, 29 Feb 2000 12:00:00 GMT");
    send_buf(63'(hdep_tb_pkg::civil_seconds(2000, 1, 29, 12, 0, 0) + 1));
    // Feb 30 of a non-leap century year lands on Mar 2
    load_text("Mon, 30 feb 2100 00:00:00 GMT");
    send_buf('0);
    load_text("Sun; 06 Nov 1994 08:49:37 GMT");
    send_buf('0);
    load_text("Sun,_06 Nov 1994 08:49:37 GMT");
    send_buf('0);
    load_text("Sun, 06 Nov 1994 08:49:37 gmt");
    send_buf('0);
    load_text("Sun, 06 Nov 1994 08:49:37 GM");
    send_buf('0);
    load_text("Sun, 00 Nov 1994 08:49:37 GMT");
    send_buf('0);
    load_text("Sun, 32 Nov 1994 08:49:37 GMT");
    send_buf('0);
    load_text("Sun, 06 Nox 1994 08:49:37 GMT");
    send_buf('0);
    load_text("Sun, 06 Nov 1969 23:59:59 GMT");
    send_buf('0);
    load_text("Sun, 06 Nov 1994 24:00:00 GMT");
    send_buf('0);
    load_text("Sun, 06 Nov 1994 23:60:00 GMT");
    send_buf('0);
    load_text("Sun, 06 Nov 1994 23:59:60 GMT");
    send_buf('0);
    load_text("Sun, 6x Nov 1994 08:49:37 GMT");
    send_buf('0);
    load_text("Sun, 06 Nov 19a4 08:49:37 GMT");
    send_buf('0);
    load_text("Sun, 06 Nov 1994 08:49:37 GMT; path=/");
    send_buf('0);
    load_text("Wed, 09 Jun 2021 10:18:14 UTC");
    date_buf[0] = 8'h00;
    date_buf[1] = 8'hFF;
    date_buf[7] = 8'h80;
    date_buf[25] = 8'h00;
    send_buf('0);
    load_text("x");
    send_buf(rand63());
  endtask

  task automatic random_date();
    int kind, d, m, y, h, mi, s;
    longint unsigned secs;
    logic [62:0] now;
    string zone;
    kind = $urandom_range(0, 99);
    d = $urandom_range(1, 31);
    m = $urandom_range(0, 11);
    y = ($urandom_range(0, 3) != 0) ? $urandom_range(1970, 2100) : $urandom_range(1970, 9999);
    h = $urandom_range(0, 23);
    mi = $urandom_range(0, 59);
    s = $urandom_range(0, 59);
    zone = ($urandom_range(0, 1) != 0) ? "GMT" : "UTC";
    secs = hdep_tb_pkg::civil_seconds(y, m, d, h, mi, s);
    now = pick_now(secs);
    if (kind >= 55 && kind < 65) begin
      case ($urandom_range(0, 5))
        0: d = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(32, 99);
        1: m = -1;
        2: y = $urandom_range(0, 1969);
        3: h = $urandom_range(24, 99);
        4: mi = $urandom_range(60, 99);
        default: s = $urandom_range(60, 99);
      endcase
    end
    if (kind >= 73 && kind < 81) begin
      case ($urandom_range(0, 4))
        0: zone = "gmt";
        1: zone = "Utc";
        2: zone = "GMX";
        3: zone = "UT ";
        default: zone = $sformatf("%c%c%c", 8'($urandom_range(33, 126)),
                                  8'($urandom_range(33, 126)), 8'($urandom_range(33, 126)));
      endcase
    end
    load_date(d, m, y, h, mi, s, zone);
    if (kind >= 65 && kind < 73) begin
      case ($urandom_range(0, 2))
        0: date_buf[3] = odd_byte();
        1: date_buf[4] = odd_byte();
        default: begin
          date_buf[3] = odd_byte();
          date_buf[4] = odd_byte();
        end
      endcase
    end else if (kind >= 81 && kind < 87) begin
      repeat ($urandom_range(1, 28)) void'(date_buf.pop_back());
    end else if (kind >= 87 && kind < 93) begin
      repeat ($urandom_range(1, 12)) date_buf.push_back(odd_byte());
    end else if (kind >= 93) begin
      if ($urandom_range(0, 2) == 0) begin
        date_buf.delete();
        repeat ($urandom_range(25, 35)) date_buf.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 3)) date_buf[$urandom_range(0, 28)] = odd_byte();
      end
    end
    send_buf(now);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_push <= 1'b0;
    in_byte <= '0;
    in_last <= 1'b0;
    in_now_seconds <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    directed_dates();
    while (n_bytes < BYTE_TARGET) random_date();
    in_push <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d date strings in %0d bytes: layout, zone, range, length and expiry cases.",
             n_strings, n_bytes);
    $display("Checked %0d results: %0d ok, %0d expired, %0d rejected.", results_all, results_ok,
             results_expired, results_all - results_ok - results_expired);
    if (fail_count == 0) begin
      $display("** http_date_expiry_parser_core: PASSED **");
    end else begin
      $display("** http_date_expiry_parser_core: FAILED **");
    end
    $finish;
  end

endmodule
